@@ src/iibs_pkg.sv @@
package iibs_pkg;

  localparam int DEF_MAX_ROWS = 256;
  localparam int DEF_MAX_COLS = 256;

  localparam int ENTRY_W   = 24;
  localparam int PIXEL_W   = 8;
  localparam int COORD_W   = 8;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam int S_DATA_W  = 32;
  localparam int S_USER_W  = 2;
  localparam int M_DATA_W  = 24;

  localparam logic [CFG_W-1:0] CFG_DIM_RESET = 9'd256;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS = 1'b1;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  // Corner read order of a query: the two subtracted corners sit in the middle.
  typedef enum logic [1:0] {
    CORNER_LR = 2'd0,
    CORNER_LL = 2'd1,
    CORNER_UR = 2'd2,
    CORNER_UL = 2'd3
  } corner_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LD_RD,
    ST_LD_WR,
    ST_Q_RD,
    ST_Q_LAST,
    ST_Q_OUT
  } state_t;

endpackage

@@ src/integral_image_box_sum.sv @@
// Summed-area table builder with square box-sum queries.
//
// Input stream (s_*): one word per item. s_tuser[0] is the opcode (load or
// query), s_tuser[1] marks the first pixel of a frame. A load word carries a
// pixel in raster order; a query word carries a centre and a half width.
// Output stream (m_*): one word per query with the box sum and an in-range
// flag; loads produce no word. The configuration port sets the image size.
//
// The summed-area table sits in one single-port store addressed by {row, col},
// each padded to a power of two, with a registered read, so items are handled
// one at a time. A load is accepted, reads the entry above and then writes;
// a load on row 0 skips the read. A query is accepted, makes four table
// reads, folds in the last read and then loads the output register. An
// out-of-range query skips the reads.
//
// The output register lets the next item be accepted while a result waits;
// a query finishing while that register is still full holds until m_tready.
// Reset clears the load position, the row sum and the output valid, and sets
// both image dimensions to 256. The table itself is not cleared.
module integral_image_box_sum #(
  parameter int MAX_ROWS = iibs_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = iibs_pkg::DEF_MAX_COLS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // pixel_value, centre_row, centre_col, half_width (from bit 0 up)
  input  logic [iibs_pkg::S_DATA_W-1:0]  s_tdata,
  // opcode, frame_start (from bit 0 up)
  input  logic [iibs_pkg::S_USER_W-1:0]  s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // box_sum
  output logic [iibs_pkg::M_DATA_W-1:0]  m_tdata,
  // in_range
  output logic                           m_tuser,
  input  logic                           cfg_we,
  input  logic [iibs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [iibs_pkg::CFG_W-1:0]     cfg_data
);

  import iibs_pkg::*;

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int AW  = RW + CW;
  localparam int RDW = $clog2(MAX_ROWS + 1);
  localparam int CDW = $clog2(MAX_COLS + 1);

  state_t state, state_next;

  logic [CFG_W-1:0]   image_rows;
  logic [CFG_W-1:0]   image_cols;
  logic [RDW-1:0]     rows_eff;
  logic [CDW-1:0]     cols_eff;

  logic [RW-1:0]      load_row;
  logic [CW-1:0]      load_col;
  logic [ENTRY_W-1:0] row_sum;
  logic               ld_above;

  logic [RW-1:0]      q_top;
  logic [RW-1:0]      q_bot;
  logic [CW-1:0]      q_left;
  logic [CW-1:0]      q_right;
  logic               q_ok;
  corner_t            q_idx;
  logic [ENTRY_W-1:0] acc;

  // Input word unpacked.
  opcode_t             in_op;
  logic                in_fstart;
  logic [PIXEL_W-1:0]  in_pixel;
  logic [COORD_W-1:0]  in_cr;
  logic [COORD_W-1:0]  in_cc;
  logic [COORD_W-1:0]  in_hw;

  assign in_op     = opcode_t'(s_tuser[0]);
  assign in_fstart = s_tuser[1];
  assign in_pixel  = s_tdata[7:0];
  assign in_cr     = s_tdata[15:8];
  assign in_cc     = s_tdata[23:16];
  assign in_hw     = s_tdata[31:24];

  logic in_acc;
  assign in_acc = s_tvalid && s_tready;

  // Table port.
  logic               mem_en;
  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ENTRY_W-1:0] mem_rdata;

  iibs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (2 ** AW)
  ) u_store (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Effective dimensions: zero acts as one, oversize acts as the maximum.
  always_comb begin
    if (image_rows == '0) begin
      rows_eff = RDW'(1);
    end else if (32'(image_rows) > MAX_ROWS) begin
      rows_eff = RDW'(MAX_ROWS);
    end else begin
      rows_eff = RDW'(image_rows);
    end
    if (image_cols == '0) begin
      cols_eff = CDW'(1);
    end else if (32'(image_cols) > MAX_COLS) begin
      cols_eff = CDW'(MAX_COLS);
    end else begin
      cols_eff = CDW'(image_cols);
    end
  end

  // Query range check on the incoming word.
  logic [COORD_W:0]   hw_plus1;
  logic [COORD_W:0]   r_far;
  logic [COORD_W:0]   c_far;
  logic [COORD_W-1:0] r_near;
  logic [COORD_W-1:0] c_near;
  logic               q_in_ok;

  always_comb begin
    hw_plus1 = {1'b0, in_hw} + (COORD_W + 1)'(1);
    r_far    = {1'b0, in_cr} + {1'b0, in_hw};
    c_far    = {1'b0, in_cc} + {1'b0, in_hw};
    r_near   = in_cr - in_hw - COORD_W'(1);
    c_near   = in_cc - in_hw - COORD_W'(1);
    q_in_ok  = ({1'b0, in_cr} >= hw_plus1) && (32'(r_far) < 32'(rows_eff)) &&
               ({1'b0, in_cc} >= hw_plus1) && (32'(c_far) < 32'(cols_eff));
  end

  // Load position and running sum for the incoming pixel.
  logic [RW-1:0]      row_cur;
  logic [CW-1:0]      col_cur;
  logic [ENTRY_W-1:0] rsum_new;

  always_comb begin
    row_cur  = in_fstart ? '0 : load_row;
    col_cur  = in_fstart ? '0 : load_col;
    rsum_new = ((col_cur == '0) ? '0 : row_sum) + ENTRY_W'(in_pixel);
  end

  // Position advance after the write.
  logic [CW:0]        col_inc;
  logic [RW:0]        row_inc;
  logic [ENTRY_W-1:0] entry;

  assign col_inc = {1'b0, load_col} + (CW + 1)'(1);
  assign row_inc = {1'b0, load_row} + (RW + 1)'(1);
  assign entry   = row_sum + (ld_above ? mem_rdata : '0);

  // Corner whose read data arrives this cycle.
  corner_t acc_idx;
  assign acc_idx = (state == ST_Q_LAST) ? CORNER_UL : corner_t'(q_idx - 2'd1);

  logic out_load;
  assign out_load = (state == ST_Q_OUT) && (!m_tvalid || m_tready);

  // Next state and table control.
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mem_en     = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = {load_row, load_col};
    mem_wdata  = entry;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (in_op == OP_LOAD) begin
            state_next = (row_cur != '0) ? ST_LD_RD : ST_LD_WR;
          end else begin
            state_next = q_in_ok ? ST_Q_RD : ST_Q_OUT;
          end
        end
      end
      ST_LD_RD: begin
        mem_en     = 1'b1;
        mem_addr   = {load_row - RW'(1), load_col};
        state_next = ST_LD_WR;
      end
      ST_LD_WR: begin
        mem_en     = 1'b1;
        mem_we     = 1'b1;
        state_next = ST_IDLE;
      end
      ST_Q_RD: begin
        mem_en = 1'b1;
        unique case (q_idx)
          CORNER_LR: mem_addr = {q_bot, q_right};
          CORNER_LL: mem_addr = {q_bot, q_left};
          CORNER_UR: mem_addr = {q_top, q_right};
          CORNER_UL: mem_addr = {q_top, q_left};
        endcase
        if (q_idx == CORNER_UL) begin
          state_next = ST_Q_LAST;
        end
      end
      ST_Q_LAST: begin
        state_next = ST_Q_OUT;
      end
      ST_Q_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows <= CFG_DIM_RESET;
      image_cols <= CFG_DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_ROWS: image_rows <= cfg_data;
        CFG_IMAGE_COLS: image_cols <= cfg_data;
      endcase
    end
  end

  // Load position and row sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      load_row <= '0;
      load_col <= '0;
      row_sum  <= '0;
    end else if (in_acc && in_op == OP_LOAD) begin
      load_row <= row_cur;
      load_col <= col_cur;
      row_sum  <= rsum_new;
    end else if (state == ST_LD_WR) begin
      if (32'(col_inc) >= 32'(cols_eff)) begin
        load_col <= '0;
        if (32'(row_inc) >= 32'(rows_eff)) begin
          load_row <= '0;
        end else begin
          load_row <= row_inc[RW-1:0];
        end
      end else begin
        load_col <= col_inc[CW-1:0];
      end
    end
  end

  // Query datapath.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ld_above <= (row_cur != '0);
      q_top    <= RW'(r_near);
      q_bot    <= RW'(r_far);
      q_left   <= CW'(c_near);
      q_right  <= CW'(c_far);
      q_ok     <= q_in_ok;
      q_idx    <= CORNER_LR;
      acc      <= '0;
    end else begin
      if (state == ST_Q_RD) begin
        q_idx <= corner_t'(q_idx + 2'd1);
      end
      if ((state == ST_Q_RD && q_idx != CORNER_LR) || state == ST_Q_LAST) begin
        if (acc_idx == CORNER_LL || acc_idx == CORNER_UR) begin
          acc <= acc - mem_rdata;
        end else begin
          acc <= acc + mem_rdata;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= q_ok ? acc : '0;
      m_tuser <= q_ok;
    end
  end

endmodule

@@ src/iibs_ram.sv @@
module iibs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

@@ src/iibs_checker.sv @@
module iibs_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [iibs_pkg::M_DATA_W-1:0]  m_tdata,
  input logic                           m_tuser
);

  import iibs_pkg::*;

  // No word leaves the block in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word valid right after reset");

  // Items are handled one at a time, so ready drops after every accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted in two consecutive cycles");

  // A query outside the image reports a zero sum.
  a_zero_when_out: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("nonzero sum on an out-of-range query");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled output word changed");

endmodule

bind integral_image_box_sum iibs_checker u_iibs_checker (.*);
